FILE: design/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg
// shared types, constants and the segment font for the decimal display framer
// ----------------------------------------------------------------------------
package dsd_pkg;

   localparam int NumberWidth = 16;
   localparam int ValueWidth  = 10;
   localparam int DigitCount  = 3;
   localparam int WordsPerNum = 12;
   localparam int CountWidth  = 4;

   localparam logic [ValueWidth-1:0] MAX_SHOWN       = 10'd999;
   localparam logic [7:0]            CMD_DATA_AUTOINC = 8'h40;
   localparam logic [7:0]            CMD_ADDRESS      = 8'hC0;
   localparam logic [7:0]            SEG_BLANK        = 8'h00;

   // reciprocal constants for the divide-by-100 and divide-by-10 steps
   localparam logic [15:0] RECIP_100 = 16'd41;   // value * 41 >> 12, value <= 999
   localparam logic [14:0] RECIP_10  = 15'd205;  // value * 205 >> 11, value <= 99

   typedef struct packed {
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   typedef struct packed {
      logic [7:0] seg0;
      logic [7:0] seg1;
      logic [7:0] seg2;
   } segs_type;

   // common-cathode font, bit0..bit6 = segments a..g
   function automatic logic [7:0] seg_font(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'h3F;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5B;
         4'd3: code = 8'h4F;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6D;
         4'd6: code = 8'h7D;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7F;
         4'd9: code = 8'h6F;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

FILE: design/dsd_req_if.sv
// ----------------------------------------------------------------------------
// dsd_req_if
// request channel: one number to show per word
// ----------------------------------------------------------------------------
interface dsd_req_if;
   logic                              valid;
   logic                              ready;
   logic [dsd_pkg::NumberWidth-1:0]   number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

FILE: design/dsd_rsp_if.sv
// ----------------------------------------------------------------------------
// dsd_rsp_if
// response channel: one driver byte with its strobe framing per word
// ----------------------------------------------------------------------------
interface dsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   logic       frame_end;
   logic       last;

   modport source (output valid, output data_byte, output frame_start,
                   output frame_end, output last, input ready);
   modport sink   (input valid, input data_byte, input frame_start,
                   input frame_end, input last, output ready);
endinterface

FILE: design/dsd_digits.sv
// ----------------------------------------------------------------------------
// dsd_digits
// three-stage pipe: saturate, split off hundreds, split tens and units
// ----------------------------------------------------------------------------
module dsd_digits (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [dsd_pkg::NumberWidth-1:0] in_number,
   output logic                            out_valid,
   input  logic                            out_ready,
   output dsd_pkg::digits_type             out_digits
);

   logic                              v1_ff, v2_ff, v3_ff;
   logic                              adv1, adv2, adv3;
   logic [dsd_pkg::ValueWidth-1:0]    sat_ff, sat_in;
   logic [3:0]                        hund2_ff, hund2_in;
   logic [6:0]                        rem2_ff, rem2_in;
   dsd_pkg::digits_type               dig3_ff, dig3_in;

   logic [15:0]                       hund_prod;
   logic [9:0]                        hund_x100;
   logic [9:0]                        rem_full;
   logic [14:0]                       tens_prod;
   logic [3:0]                        tens_q;
   logic [6:0]                        tens_x10;
   logic [6:0]                        ones_full;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // stage 1: clamp to the largest shown value
   always_comb begin
      if (in_number > {{(dsd_pkg::NumberWidth-dsd_pkg::ValueWidth){1'b0}},
                       dsd_pkg::MAX_SHOWN}) begin
         sat_in = dsd_pkg::MAX_SHOWN;
      end else begin
         sat_in = in_number[dsd_pkg::ValueWidth-1:0];
      end
   end

   // stage 2: hundreds by reciprocal multiply, remainder below 100
   always_comb begin
      hund_prod = {6'b0, sat_ff} * dsd_pkg::RECIP_100;
      hund2_in  = hund_prod[15:12];
      hund_x100 = {6'b0, hund2_in} * 10'd100;
      rem_full  = sat_ff - hund_x100;
      rem2_in   = rem_full[6:0];
   end

   // stage 3: tens and units
   always_comb begin
      tens_prod    = {8'b0, rem2_ff} * dsd_pkg::RECIP_10;
      tens_q       = tens_prod[14:11];
      tens_x10     = {3'b0, tens_q} * 7'd10;
      ones_full    = rem2_ff - tens_x10;
      dig3_in.hund = hund2_ff;
      dig3_in.tens = tens_q;
      dig3_in.ones = ones_full[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         sat_ff <= sat_in;
      end
      if (adv2) begin
         hund2_ff <= hund2_in;
         rem2_ff  <= rem2_in;
      end
      if (adv3) begin
         dig3_ff <= dig3_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_digits = dig3_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (rem2_ff < 7'd100 && hund2_ff <= 4'd9))
      else $error("remainder or hundreds out of range");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (dig3_ff.tens <= 4'd9 && dig3_ff.ones <= 4'd9))
      else $error("tens or units digit out of range");

endmodule

FILE: design/dsd_font.sv
// ----------------------------------------------------------------------------
// dsd_font
// font lookup with leading-zero blanking, one register stage
// ----------------------------------------------------------------------------
module dsd_font (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dsd_pkg::digits_type in_digits,
   output logic                out_valid,
   input  logic                out_ready,
   output dsd_pkg::segs_type   out_segs
);

   logic              v_ff;
   dsd_pkg::segs_type segs_ff, segs_in;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      if (in_digits.hund == 4'd0) begin
         segs_in.seg0 = dsd_pkg::SEG_BLANK;
         segs_in.seg1 = (in_digits.tens == 4'd0) ? dsd_pkg::SEG_BLANK
                                                 : dsd_pkg::seg_font(in_digits.tens);
      end else begin
         segs_in.seg0 = dsd_pkg::seg_font(in_digits.hund);
         segs_in.seg1 = dsd_pkg::seg_font(in_digits.tens);
      end
      segs_in.seg2 = dsd_pkg::seg_font(in_digits.ones);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         segs_ff <= segs_in;
      end
   end

   assign out_valid = v_ff;
   assign out_segs  = segs_ff;

endmodule

FILE: design/dsd_frame.sv
// ----------------------------------------------------------------------------
// dsd_frame
// word sequencer: twelve driver bytes per number, four per digit position
// ----------------------------------------------------------------------------
module dsd_frame (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dsd_pkg::segs_type in_segs,
   dsd_rsp_if.source         rsp_chan
);

   localparam logic [dsd_pkg::CountWidth-1:0] LastCount =
      dsd_pkg::CountWidth'(dsd_pkg::WordsPerNum - 1);

   logic                              busy_ff, busy_in;
   logic [dsd_pkg::CountWidth-1:0]    cnt_ff, cnt_in;
   dsd_pkg::segs_type                 segs_ff;
   logic                              rsp_fire;
   logic                              at_last;
   logic [1:0]                        pos;
   logic [1:0]                        sub;
   logic [7:0]                        seg_sel;

   assign rsp_fire = busy_ff && rsp_chan.ready;
   assign at_last  = (cnt_ff == LastCount);
   assign in_ready = !busy_ff || (rsp_fire && at_last);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (rsp_fire) begin
         if (at_last) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
      if (in_ready && in_valid) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         segs_ff <= in_segs;
      end
   end

   // position in the upper count bits, byte within the position in the lower
   assign pos = cnt_ff[3:2];
   assign sub = cnt_ff[1:0];

   always_comb begin
      case (pos)
         2'd0:    seg_sel = segs_ff.seg0;
         2'd1:    seg_sel = segs_ff.seg1;
         2'd2:    seg_sel = segs_ff.seg2;
         default: seg_sel = dsd_pkg::SEG_BLANK;
      endcase
   end

   always_comb begin
      rsp_chan.last = 1'b0;
      case (sub)
         2'd0: begin
            rsp_chan.data_byte   = dsd_pkg::CMD_DATA_AUTOINC;
            rsp_chan.frame_start = 1'b1;
            rsp_chan.frame_end   = 1'b1;
         end
         2'd1: begin
            rsp_chan.data_byte   = dsd_pkg::CMD_ADDRESS | {5'b0, pos, 1'b0};
            rsp_chan.frame_start = 1'b1;
            rsp_chan.frame_end   = 1'b0;
         end
         2'd2: begin
            rsp_chan.data_byte   = {4'h0, seg_sel[3:0]};
            rsp_chan.frame_start = 1'b0;
            rsp_chan.frame_end   = 1'b0;
         end
         default: begin
            rsp_chan.data_byte   = {4'h0, seg_sel[7:4]};
            rsp_chan.frame_start = 1'b0;
            rsp_chan.frame_end   = 1'b1;
            rsp_chan.last        = at_last;
         end
      endcase
   end

   assign rsp_chan.valid = busy_ff;

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !at_last) |=> (busy_ff && cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("word counter did not step after a taken word");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= LastCount))
      else $error("word counter beyond the last word");

endmodule

FILE: design/decimal_to_segment_display_frames.sv
// ----------------------------------------------------------------------------
// decimal_to_segment_display_frames
// three-digit decimal display byte stream for a seven-segment driver
// ----------------------------------------------------------------------------
// Each number taken on req_chan is clamped to 999, split into decimal digits,
// mapped to segment codes with leading zeros blanked, and sent on rsp_chan as
// twelve bytes: per digit position a data command frame and an address frame
// carrying the low and high segment nibbles. The result channel moves one
// word per cycle while rsp_chan.ready holds, and the last word of one number
// can be followed directly by the first word of the next. A number passes
// through the saturate, hundreds split, tens/units split and font stages,
// then the word sequencer, before its first word is offered. The next number
// is taken while the current one is still being sent and waits in the pipe.
// ----------------------------------------------------------------------------
module decimal_to_segment_display_frames (
   input  logic      clock,
   input  logic      reset,
   dsd_req_if.sink   req_chan,
   dsd_rsp_if.source rsp_chan
);

   logic                dig_valid, dig_ready;
   dsd_pkg::digits_type dig_data;
   logic                seg_valid, seg_ready;
   dsd_pkg::segs_type   seg_data;

   dsd_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_number  (req_chan.number),
      .out_valid  (dig_valid),
      .out_ready  (dig_ready),
      .out_digits (dig_data)
   );

   dsd_font u_font (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dig_valid),
      .in_ready  (dig_ready),
      .in_digits (dig_data),
      .out_valid (seg_valid),
      .out_ready (seg_ready),
      .out_segs  (seg_data)
   );

   dsd_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .in_valid (seg_valid),
      .in_ready (seg_ready),
      .in_segs  (seg_data),
      .rsp_chan (rsp_chan)
   );

endmodule
